// ===== src/flss_pkg.sv =====
// shared types and codes for the fault latching safety supervisor
package flss_pkg;

  localparam int TIME_W = 32;
  localparam int SEQ_W = 32;
  localparam int TMO_W = 16;
  localparam int HEALTH_W = 6;
  localparam int STATE_W = 2;
  localparam int FAULT_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W = 176;
  localparam int OUT_DATA_W = 8;

  // robot state codes
  localparam logic [STATE_W-1:0] ST_DISARMED = 2'd0;
  localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STATE_W-1:0] ST_FAULT = 2'd2;
  localparam logic [STATE_W-1:0] ST_ESTOP = 2'd3;

  // fault codes
  localparam logic [FAULT_W-1:0] FC_NONE = 4'd0;
  localparam logic [FAULT_W-1:0] FC_ESTOP = 4'd1;
  localparam logic [FAULT_W-1:0] FC_SENSOR_INVALID = 4'd2;
  localparam logic [FAULT_W-1:0] FC_CALIBRATION = 4'd3;
  localparam logic [FAULT_W-1:0] FC_NONFINITE = 4'd4;
  localparam logic [FAULT_W-1:0] FC_JOINT_LIMIT = 4'd5;
  localparam logic [FAULT_W-1:0] FC_SENSOR_TIMEOUT = 4'd6;
  localparam logic [FAULT_W-1:0] FC_LINK_LOST = 4'd7;
  localparam logic [FAULT_W-1:0] FC_COMMAND_TIMEOUT = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TIMEOUT = 1'd1;

  localparam logic [TMO_W-1:0] SENSOR_TIMEOUT_RST = 16'd200;
  localparam logic [TMO_W-1:0] COMMAND_TIMEOUT_RST = 16'd500;

  // health flag bit positions
  localparam int HF_JOINTS_VALID = 0;
  localparam int HF_JOINTS_FINITE = 1;
  localparam int HF_JOINTS_LIMITS = 2;
  localparam int HF_IMU_VALID = 3;
  localparam int HF_IMU_FINITE = 4;
  localparam int HF_CMD_FINITE = 5;

  typedef struct packed {
    logic [STATE_W-1:0] robot_state;
    logic [FAULT_W-1:0] fault;
    logic need_seq;
    logic [SEQ_W-1:0] cleared_seq;
    logic [TIME_W-1:0] imu_start;
    logic imu_timing;
  } flss_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] command_received_ms;
    logic [TIME_W-1:0] joints_stamp_ms;
    logic [TIME_W-1:0] imu_stamp_ms;
    logic emergency_stop;
    logic clear_fault_request;
    logic enable_request;
    logic command_valid;
    logic [SEQ_W-1:0] command_sequence;
    logic ble_connected;
    logic calibration_ok;
    logic [HEALTH_W-1:0] health_flags;
  } flss_item_t;

endpackage

// ===== src/flss_step.sv =====
// one supervisor evaluation: fault latching, imu loss timer and priority chain
module flss_step
  import flss_pkg::*;
(
  input  flss_item_t        item,
  input  flss_state_t       cur,
  input  logic [TMO_W-1:0]  sensor_timeout_ms,
  input  logic [TMO_W-1:0]  command_timeout_ms,
  output flss_state_t       nxt
);

  logic [TIME_W-1:0] joints_age;
  logic [TIME_W-1:0] imu_age;
  logic [TIME_W-1:0] cmd_age;
  logic [TIME_W-1:0] loss_age;
  logic [TIME_W-1:0] sto_ext;
  logic [TIME_W-1:0] cto_ext;
  logic joints_valid, joints_ok, joints_in_limits, imu_valid, imu_ok, cmd_finite;
  logic joints_fresh, imu_fresh, cmd_fresh;
  logic causes_gone;
  logic latched_a;
  logic latched_b;
  flss_state_t s;

  assign joints_valid = item.health_flags[HF_JOINTS_VALID];
  assign joints_ok = joints_valid && item.health_flags[HF_JOINTS_FINITE];
  assign joints_in_limits = item.health_flags[HF_JOINTS_LIMITS];
  assign imu_valid = item.health_flags[HF_IMU_VALID];
  assign imu_ok = imu_valid && item.health_flags[HF_IMU_FINITE];
  assign cmd_finite = !item.command_valid || item.health_flags[HF_CMD_FINITE];

  assign sto_ext = {{(TIME_W-TMO_W){1'b0}}, sensor_timeout_ms};
  assign cto_ext = {{(TIME_W-TMO_W){1'b0}}, command_timeout_ms};

  assign joints_age = item.now_ms - item.joints_stamp_ms;
  assign imu_age = item.now_ms - item.imu_stamp_ms;
  assign cmd_age = item.now_ms - item.command_received_ms;
  assign joints_fresh = joints_age <= sto_ext;
  assign imu_fresh = imu_age <= sto_ext;
  assign cmd_fresh = cmd_age <= cto_ext;

  // a loss that starts this cycle has age zero
  assign loss_age = cur.imu_timing ? (item.now_ms - cur.imu_start) : '0;

  assign causes_gone = !item.emergency_stop && item.calibration_ok && joints_ok && imu_ok
                    && item.ble_connected && item.command_valid && cmd_finite
                    && joints_fresh && imu_fresh && cmd_fresh;

  always_comb begin
    s = cur;

    if (item.emergency_stop) begin
      s.fault = FC_ESTOP;
      s.robot_state = ST_ESTOP;
    end

    if (imu_valid) begin
      s.imu_timing = 1'b0;
      s.imu_start = '0;
    end else if (!cur.imu_timing) begin
      s.imu_timing = 1'b1;
      s.imu_start = item.now_ms;
    end

    latched_a = (s.robot_state == ST_FAULT) || (s.robot_state == ST_ESTOP);
    if (!imu_valid && !latched_a && (loss_age >= sto_ext)) begin
      s.fault = FC_SENSOR_INVALID;
      s.robot_state = ST_FAULT;
    end

    latched_b = (s.robot_state == ST_FAULT) || (s.robot_state == ST_ESTOP);
    priority if (latched_b) begin
      if (item.clear_fault_request && causes_gone
          && (item.command_sequence != cur.cleared_seq)) begin
        s.robot_state = ST_DISARMED;
        s.fault = FC_NONE;
        s.need_seq = 1'b1;
        s.cleared_seq = item.command_sequence;
      end
    end else if (!item.calibration_ok) begin
      s.fault = FC_CALIBRATION;
      s.robot_state = ST_FAULT;
    end else if (!joints_valid) begin
      s.fault = FC_SENSOR_INVALID;
      s.robot_state = ST_FAULT;
    end else if (!joints_ok) begin
      s.fault = FC_NONFINITE;
      s.robot_state = ST_FAULT;
    end else if (!imu_valid) begin
      // short imu dropout holds the robot disarmed without a fault
      s.robot_state = ST_DISARMED;
      s.fault = FC_NONE;
    end else if (!imu_ok) begin
      s.fault = FC_NONFINITE;
      s.robot_state = ST_FAULT;
    end else if (!joints_in_limits) begin
      s.fault = FC_JOINT_LIMIT;
      s.robot_state = ST_FAULT;
    end else if (!joints_fresh || !imu_fresh) begin
      s.fault = FC_SENSOR_TIMEOUT;
      s.robot_state = ST_FAULT;
    end else if (!item.ble_connected) begin
      s.fault = FC_LINK_LOST;
      s.robot_state = ST_FAULT;
    end else if (!item.command_valid || !cmd_fresh) begin
      s.fault = FC_COMMAND_TIMEOUT;
      s.robot_state = ST_FAULT;
    end else if (!cmd_finite) begin
      s.fault = FC_NONFINITE;
      s.robot_state = ST_FAULT;
    end else if (!item.enable_request) begin
      s.robot_state = ST_DISARMED;
      s.fault = FC_NONE;
    end else if (cur.need_seq && (item.command_sequence == cur.cleared_seq)) begin
      // re-arm waits for a sequence number other than the cleared one
      s.robot_state = ST_DISARMED;
    end else begin
      s.robot_state = ST_RUNNING;
      s.fault = FC_NONE;
      s.need_seq = 1'b0;
    end

    nxt = s;
  end

endmodule

// ===== src/fault_latching_safety_supervisor.sv =====
// Fault latching safety supervisor top level with input and result registers
//
// One request per control cycle enters on the in_ stream: current time, the
// command, joint and imu timestamps, command flags and sequence, link and
// calibration status and sensor health flags. Each request yields exactly
// one result on the out_ stream: motion permit, robot state and fault code.
// Faults and emergency stop latch until a clear request with a new sequence
// number arrives while every cause is gone; re-arming then needs yet another
// sequence number.
// An accepted request is held in the input register; when the result
// register is empty or being drained, the decision logic writes the result
// register and the supervisor state together. One request per cycle goes
// through while the receiver does not stall, as the decision path between
// the two registers is combinational.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; in_tready drops only when both are
// full. Reset clears the stream valids, restores the default timeouts
// (200 ms sensor, 500 ms command) and returns to disarmed with no fault. The
// user must write timeouts on the cfg_ port only while idle; not enforced.
module fault_latching_safety_supervisor
  import flss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // now_ms[31:0], command_received_ms[63:32], joints_stamp_ms[95:64],
  // imu_stamp_ms[127:96], emergency_stop[128], clear_fault_request[129],
  // enable_request[130], command_valid[131], command_sequence[163:132],
  // ble_connected[164], calibration_ok[165], health_flags[171:166], zero fill
  input  logic [IN_DATA_W-1:0]    in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // motion_permitted[0], robot_state[2:1], fault_code[6:3], zero fill
  output logic [OUT_DATA_W-1:0]   out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_addr,
  input  logic [TMO_W-1:0]        cfg_wdata
);

  logic                   in_v_r;
  logic                   in_v_nxt;
  flss_item_t             item_r;
  logic                   out_v_r;
  logic                   out_v_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;
  flss_state_t            st_r;
  flss_state_t            st_nxt;
  flss_state_t            step_res;
  logic [TMO_W-1:0]       sto_r;
  logic [TMO_W-1:0]       cto_r;
  logic                   advance;
  logic                   in_fire;

  assign advance = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_fire = in_tvalid && in_tready;

  assign in_v_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : in_v_r);
  assign out_v_nxt = advance ? 1'b1 : ((out_v_r && out_tready) ? 1'b0 : out_v_r);

  flss_step u_step (
    .item               (item_r),
    .cur                (st_r),
    .sensor_timeout_ms  (sto_r),
    .command_timeout_ms (cto_r),
    .nxt                (step_res)
  );

  assign st_nxt = advance ? step_res : st_r;
  assign out_data_nxt = {1'b0, step_res.fault, step_res.robot_state,
                         (step_res.robot_state == ST_RUNNING)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{robot_state: ST_DISARMED, fault: FC_NONE, need_seq: 1'b0,
                   cleared_seq: '0, imu_start: '0, imu_timing: 1'b0};
      sto_r   <= SENSOR_TIMEOUT_RST;
      cto_r   <= COMMAND_TIMEOUT_RST;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SENSOR_TIMEOUT:  sto_r <= cfg_wdata;
          CFG_COMMAND_TIMEOUT: cto_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.now_ms              <= in_tdata[31:0];
      item_r.command_received_ms <= in_tdata[63:32];
      item_r.joints_stamp_ms     <= in_tdata[95:64];
      item_r.imu_stamp_ms        <= in_tdata[127:96];
      item_r.emergency_stop      <= in_tdata[128];
      item_r.clear_fault_request <= in_tdata[129];
      item_r.enable_request      <= in_tdata[130];
      item_r.command_valid       <= in_tdata[131];
      item_r.command_sequence    <= in_tdata[163:132];
      item_r.ble_connected       <= in_tdata[164];
      item_r.calibration_ok      <= in_tdata[165];
      item_r.health_flags        <= in_tdata[171:166];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;

endmodule
